// File: rtl/core/bppq_pkg.sv
// ----------------------------------------------------------------------------
// bppq_pkg
// Shared types, request and status codes for the bounded priority queue.
// ----------------------------------------------------------------------------
package bppq_pkg;

	localparam int DEPTH_DEFAULT = 16;

	// request codes
	localparam logic [1:0] REQ_ENQUEUE = 2'd0;
	localparam logic [1:0] REQ_DEQUEUE = 2'd1;
	localparam logic [1:0] REQ_PEEK    = 2'd2;
	localparam logic [1:0] REQ_UNUSED  = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_DROPPED = 2'd1;
	localparam logic [1:0] STATUS_EMPTY   = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] pkt_id;
		logic [7:0]  priority_req;
		logic [15:0] size_bytes;
		logic [7:0]  source_node;
		logic [7:0]  dest_node;
		logic [31:0] arrival_time;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] item_id;
		logic [7:0]  item_priority;
		logic [15:0] item_size;
		logic [7:0]  item_source;
		logic [7:0]  item_dest;
		logic [31:0] item_arrival;
		logic [4:0]  occupancy;
		logic        is_empty;
		logic        is_full;
		logic [31:0] dropped_total;
		logic [31:0] served_total;
	} rsp_t;

	// one stored descriptor
	typedef struct packed {
		logic [7:0]  prio;
		logic [15:0] id;
		logic [15:0] size;
		logic [7:0]  source;
		logic [7:0]  dest;
		logic [31:0] arrival;
	} entry_t;

endpackage

// File: rtl/core/bppq_store.sv
// ----------------------------------------------------------------------------
// bppq_store
// Descriptor ring memory: one write and one registered read per cycle,
// addressed relative to the ring head.
// ----------------------------------------------------------------------------
module bppq_store #(
	parameter int DEPTH = bppq_pkg::DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic [$clog2(DEPTH)-1:0]     head,
	input  logic                         rd_en,
	input  logic [$clog2(DEPTH)-1:0]     rd_rel,
	output bppq_pkg::entry_t             rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(DEPTH)-1:0]     wr_rel,
	input  bppq_pkg::entry_t             wr_data
);
	import bppq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

	entry_t mem [DEPTH];

	function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
	                                            input logic [AW-1:0] rel);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, rel};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[AW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ring_addr(head, wr_rel)] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[ring_addr(head, rd_rel)];
		end
	end

endmodule

// File: rtl/core/bounded_priority_packet_queue_core.sv
// ----------------------------------------------------------------------------
// bounded_priority_packet_queue_core
// Priority queue of packet descriptors, highest priority at the head and
// arrival order kept among equal priorities.
// ----------------------------------------------------------------------------
// Sequence: a dequeue or peek on a filled queue reads the head at accept,
//   then passes S_HEAD and S_FIN; drops, unused codes and empty reads go
//   straight to S_FIN; an enqueue steps S_SCAN and S_CMP for each stored
//   entry of lower priority that moves one place toward the tail.
// Throughput: one request at a time; the insertion walk through the ring
//   memory store (read, compare, write back) sets the enqueue time, and
//   a stalled earlier result holds the finished request until it drains.
// Reset: arst_n clears occupancy, both counters, capacity register and the
//   handshake state; the descriptor memory keeps no reset value.
// ----------------------------------------------------------------------------
module bounded_priority_packet_queue_core #(
	parameter int DEPTH = bppq_pkg::DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [4:0]       capacity_limit,
	// request channel
	input  logic             in_valid,
	output logic             in_ready,
	input  bppq_pkg::req_t   in_req,
	// result channel
	output logic             out_valid,
	input  logic             out_ready,
	output bppq_pkg::rsp_t   out_rsp
);
	import bppq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > 5) ? CW : 5;
	localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;  // pick next slot to examine
	localparam logic [2:0] S_CMP  = 3'd2;  // compare fetched entry, shift or insert
	localparam logic [2:0] S_HEAD = 3'd3;  // head entry arrived from memory
	localparam logic [2:0] S_FIN  = 3'd4;  // publish result

	logic [2:0]    state_q;
	logic [4:0]    cap_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   drop_q;
	logic [31:0]   serve_q;
	req_t          req_q;
	rsp_t          res_q;     // status and item fields of the request at work
	rsp_t          out_q;
	logic          out_valid_q;

	// store interface
	logic          rd_en;
	logic [AW-1:0] rd_rel;
	entry_t        rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_rel;
	entry_t        wr_data;

	logic          accept;
	logic [EW-1:0] eff_cap;
	logic [EW-1:0] count_e;
	logic          at_cap;
	logic          out_free;
	entry_t        new_entry;
	rsp_t          res_init;  // result fields known at accept
	rsp_t          res_head;  // result fields with the head entry filled in
	rsp_t          out_next;  // complete result for the output register

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// capacity 0 or beyond the store means the store depth
	assign eff_cap = ((cap_q == 5'd0) || (EW'(cap_q) > DEPTH_E)) ? DEPTH_E : EW'(cap_q);
	assign count_e = EW'(count_q);
	assign at_cap  = (count_e >= eff_cap);

	assign new_entry = '{
		prio:    req_q.priority_req,
		id:      req_q.pkt_id,
		size:    req_q.size_bytes,
		source:  req_q.source_node,
		dest:    req_q.dest_node,
		arrival: req_q.arrival_time
	};

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_rel  = '0;
		wr_en   = 1'b0;
		wr_rel  = idx_q[AW-1:0];
		wr_data = new_entry;
		unique case (state_q)
			S_IDLE: begin
				// fetch the head right away for a dequeue or peek
				rd_en = accept && count_q != '0 &&
				        (in_req.req_type == REQ_DEQUEUE || in_req.req_type == REQ_PEEK);
			end
			S_SCAN: begin
				if (idx_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en  = 1'b1;
					rd_rel = AW'(idx_q - 1'b1);
				end
			end
			S_CMP: begin
				wr_en = 1'b1;
				// lower priority entry moves one place toward the tail
				if (rd_data.prio < req_q.priority_req) begin
					wr_data = rd_data;
				end
			end
			default: begin
			end
		endcase
	end

	bppq_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.head    (head_q),
		.rd_en   (rd_en),
		.rd_rel  (rd_rel),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_rel  (wr_rel),
		.wr_data (wr_data)
	);

	// status decided at accept; item fields stay zero unless the head is read
	always_comb begin
		res_init = '0;
		unique case (in_req.req_type)
			REQ_ENQUEUE: begin
				if (at_cap) begin
					res_init.status = STATUS_DROPPED;
				end
			end
			REQ_DEQUEUE, REQ_PEEK: begin
				if (count_q == '0) begin
					res_init.status = STATUS_EMPTY;
				end
			end
			default: begin
			end
		endcase
	end

	// copy the head entry into the item fields
	always_comb begin
		res_head               = res_q;
		res_head.item_id       = rd_data.id;
		res_head.item_priority = rd_data.prio;
		res_head.item_size     = rd_data.size;
		res_head.item_source   = rd_data.source;
		res_head.item_dest     = rd_data.dest;
		res_head.item_arrival  = rd_data.arrival;
	end

	// add the queue status after the request
	always_comb begin
		out_next               = res_q;
		out_next.occupancy     = count_e[4:0];
		out_next.is_empty      = (count_q == '0);
		out_next.is_full       = at_cap;
		out_next.dropped_total = drop_q;
		out_next.served_total  = serve_q;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_req;
			res_q <= res_init;
		end else if (state_q == S_HEAD) begin
			res_q <= res_head;
		end
		if (state_q == S_FIN && out_free) begin
			out_q <= out_next;
		end
	end

	// sequencer and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= '0;
			count_q     <= '0;
			head_q      <= '0;
			idx_q       <= '0;
			drop_q      <= '0;
			serve_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= capacity_limit;
			end
			// post a finished result, or drop the one just taken
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (in_req.req_type)
							REQ_ENQUEUE: begin
								if (at_cap) begin
									// drop and count, saturating
									if (drop_q != '1) begin
										drop_q <= drop_q + 32'd1;
									end
									state_q <= S_FIN;
								end else begin
									idx_q   <= count_q;
									state_q <= S_SCAN;
								end
							end
							REQ_DEQUEUE, REQ_PEEK: begin
								state_q <= (count_q != '0) ? S_HEAD : S_FIN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (idx_q == '0) begin
						count_q <= count_q + 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (rd_data.prio >= req_q.priority_req) begin
						// new entry lands behind this one
						count_q <= count_q + 1'b1;
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_HEAD: begin
					if (req_q.req_type == REQ_DEQUEUE) begin
						// advance the ring head past the served entry
						head_q  <= (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
						count_q <= count_q - 1'b1;
						if (serve_q != '1) begin
							serve_q <= serve_q + 32'd1;
						end
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold until the result register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/bppq_checker.sv
// ----------------------------------------------------------------------------
// bppq_checker
// Port-level checks for the bounded priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module bppq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input bppq_pkg::rsp_t out_rsp
);
	import bppq_pkg::*;

	// one request at a time: ready drops after every accepted request
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one in work");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_rsp))
		else $error("result changed while stalled");

	// a dropped enqueue only happens on a full queue and returns no item
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rsp.status == STATUS_DROPPED |->
			out_rsp.is_full && out_rsp.item_id == 16'd0 && out_rsp.item_arrival == 32'd0)
		else $error("drop reported on a queue that is not full");

	// an empty report only comes from an empty queue
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rsp.status == STATUS_EMPTY |-> out_rsp.is_empty && !out_rsp.is_full)
		else $error("empty status with entries queued");

	// empty flag agrees with the occupancy count
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rsp.is_empty |-> out_rsp.occupancy == 5'd0)
		else $error("empty flag with nonzero occupancy");

endmodule

bind bounded_priority_packet_queue_core bppq_checker u_bppq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_rsp   (out_rsp)
);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded priority packet queue. A driver feeds
// requests and capacity writes from a backlog with random gaps, a scoreboard
// model predicts every response on accept, and a monitor with random
// back-pressure compares each response field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bppq_pkg::*;

	localparam int DEPTH       = DEPTH_DEFAULT;
	localparam int PHASE_ITEMS = 230;   // random requests per capacity setting
	localparam int SETTLE      = 6;     // quiet cycles before a drained write
	localparam int TAIL_CYCLES = 60;    // covers the longest insertion walk
	localparam int IDLE_LIMIT  = 4000;  // cycles without any handshake

	// one entry of the driver backlog: either a request or a capacity write
	typedef struct {
		bit           is_cfg;
		bit           drain;  // hold until every response is back
		logic [4:0]   cap;
		req_t         req;
		int unsigned  gap;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [4:0] capacity_limit = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	req_t       in_req = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	rsp_t       out_rsp;

	// scoreboard copy of the queue
	entry_t      model_store [DEPTH];
	int          model_count = 0;
	logic [31:0] model_drops = '0;
	logic [31:0] model_served = '0;
	logic [4:0]  model_cap = '0;

	stim_t       req_backlog[$];
	rsp_t        rsp_expected[$];
	int unsigned fail_count = 0;
	int unsigned pushed_count = 0;
	int unsigned rsp_count = 0;
	int unsigned idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bounded_priority_packet_queue_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.capacity_limit (capacity_limit),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_req         (in_req),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_rsp        (out_rsp)
	);

	// ------------------------------------------------------------------------
	// Response prediction: apply one request to the scoreboard queue and
	// return what the block must report for it.
	// ------------------------------------------------------------------------
	function automatic rsp_t predict_response(req_t r);
		rsp_t res;
		int   eff;
		int   pos;
		int   i;
		res = '0;
		// a limit of zero or above the store depth means the full store
		eff = (model_cap == 0 || model_cap > DEPTH) ? DEPTH : int'(model_cap);
		case (r.req_type)
			REQ_ENQUEUE: begin
				if (model_count >= eff) begin
					res.status = STATUS_DROPPED;
					if (model_drops != '1)
						model_drops++;
				end else begin
					// walk past every entry of equal or higher priority
					pos = 0;
					while (pos < model_count && model_store[pos].prio >= r.priority_req)
						pos++;
					for (i = model_count; i > pos; i--)
						model_store[i] = model_store[i - 1];
					model_store[pos] = '{prio: r.priority_req, id: r.pkt_id,
						size: r.size_bytes, source: r.source_node,
						dest: r.dest_node, arrival: r.arrival_time};
					model_count++;
				end
			end
			REQ_DEQUEUE, REQ_PEEK: begin
				if (model_count == 0) begin
					res.status = STATUS_EMPTY;
				end else begin
					res.status        = STATUS_DONE;
					res.item_id       = model_store[0].id;
					res.item_priority = model_store[0].prio;
					res.item_size     = model_store[0].size;
					res.item_source   = model_store[0].source;
					res.item_dest     = model_store[0].dest;
					res.item_arrival  = model_store[0].arrival;
					if (r.req_type == REQ_DEQUEUE) begin
						for (i = 1; i < model_count; i++)
							model_store[i - 1] = model_store[i];
						model_count--;
						if (model_served != '1)
							model_served++;
					end
				end
			end
			default: begin
				// unused code: report status only, leave the queue alone
				res.status = STATUS_DONE;
			end
		endcase
		res.occupancy     = 5'(model_count);
		res.is_empty      = (model_count == 0);
		res.is_full       = (model_count >= eff);
		res.dropped_total = model_drops;
		res.served_total  = model_served;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Driver: present backlog entries one at a time. Inputs change only with
	// nonblocking assignments at the rising edge; each valid gets exactly one
	// assignment per edge so a back-to-back request never drops for a step.
	// ------------------------------------------------------------------------
	int unsigned gap_left = 0;
	bit          gap_armed = 1'b0;
	int unsigned quiet_cycles = 0;

	always @(posedge clk or negedge arst_n) begin
		logic  nxt_in_valid;
		logic  nxt_cfg_valid;
		stim_t item;
		if (!arst_n) begin
			in_valid       <= 1'b0;
			cfg_valid      <= 1'b0;
			in_req         <= '0;
			capacity_limit <= '0;
			gap_armed      = 1'b0;
			gap_left       = 0;
			quiet_cycles   = 0;
		end else begin
			nxt_in_valid  = in_valid;
			nxt_cfg_valid = cfg_valid;

			// the block is quiet once nothing is in flight or outstanding
			if (in_valid || rsp_expected.size() != 0)
				quiet_cycles = 0;
			else if (quiet_cycles < SETTLE)
				quiet_cycles++;

			if (in_valid && in_ready) begin
				rsp_expected.push_back(predict_response(in_req));
				nxt_in_valid = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				model_cap     = capacity_limit;
				nxt_cfg_valid = 1'b0;
			end

			if (!nxt_in_valid && !nxt_cfg_valid && req_backlog.size() != 0) begin
				// draw the idle gap once per entry, then count it down
				if (!gap_armed) begin
					gap_left  = req_backlog[0].gap;
					gap_armed = 1'b1;
				end
				if (gap_left > 0) begin
					gap_left--;
				end else if (!(req_backlog[0].drain && quiet_cycles >= SETTLE)
						&& req_backlog[0].drain) begin
					// hold until every response has come back
				end else begin
					item      = req_backlog.pop_front();
					gap_armed = 1'b0;
					if (item.is_cfg) begin
						nxt_cfg_valid = 1'b1;
						capacity_limit <= item.cap;
					end else begin
						nxt_in_valid = 1'b1;
						in_req <= item.req;
					end
				end
			end

			in_valid  <= nxt_in_valid;
			cfg_valid <= nxt_cfg_valid;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: random back-pressure and in-order comparison.
	// ------------------------------------------------------------------------
	task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
		$display("%0t: mismatch on %s, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		fail_count++;
	endtask

	int unsigned stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (rsp_expected.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual 0x%0h",
						$time, out_rsp);
					fail_count++;
				end else begin
					want = rsp_expected.pop_front();
					if (out_rsp.status !== want.status)
						flag_field("status", 32'(want.status), 32'(out_rsp.status));
					if (out_rsp.item_id !== want.item_id)
						flag_field("item_id", 32'(want.item_id), 32'(out_rsp.item_id));
					if (out_rsp.item_priority !== want.item_priority)
						flag_field("item_priority", 32'(want.item_priority),
							32'(out_rsp.item_priority));
					if (out_rsp.item_size !== want.item_size)
						flag_field("item_size", 32'(want.item_size), 32'(out_rsp.item_size));
					if (out_rsp.item_source !== want.item_source)
						flag_field("item_source", 32'(want.item_source),
							32'(out_rsp.item_source));
					if (out_rsp.item_dest !== want.item_dest)
						flag_field("item_dest", 32'(want.item_dest), 32'(out_rsp.item_dest));
					if (out_rsp.item_arrival !== want.item_arrival)
						flag_field("item_arrival", want.item_arrival, out_rsp.item_arrival);
					if (out_rsp.occupancy !== want.occupancy)
						flag_field("occupancy", 32'(want.occupancy), 32'(out_rsp.occupancy));
					if (out_rsp.is_empty !== want.is_empty)
						flag_field("is_empty", 32'(want.is_empty), 32'(out_rsp.is_empty));
					if (out_rsp.is_full !== want.is_full)
						flag_field("is_full", 32'(want.is_full), 32'(out_rsp.is_full));
					if (out_rsp.dropped_total !== want.dropped_total)
						flag_field("dropped_total", want.dropped_total, out_rsp.dropped_total);
					if (out_rsp.served_total !== want.served_total)
						flag_field("served_total", want.served_total, out_rsp.served_total);
				end
				rsp_count++;
				// stretches of full-rate draining between stalled stretches
				stall_left = ((rsp_count / 50) % 3 == 1) ? 0 : $urandom_range(0, 13);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: count cycles in which no handshake completes.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	task automatic push_request(logic [1:0] code, logic [15:0] id, logic [7:0] prio,
			logic [15:0] size, logic [7:0] src, logic [7:0] dst, logic [31:0] arr,
			bit drain);
		stim_t s;
		s.is_cfg = 1'b0;
		s.drain  = drain;
		s.cap    = '0;
		s.req    = '{req_type: code, pkt_id: id, priority_req: prio, size_bytes: size,
			source_node: src, dest_node: dst, arrival_time: arr};
		// alternate back-to-back stretches with randomly gapped ones
		s.gap    = ((pushed_count / 40) % 3 == 0) ? 0 : $urandom_range(0, 13);
		req_backlog.push_back(s);
		pushed_count++;
	endtask

	task automatic push_capacity(logic [4:0] cap);
		stim_t s;
		s.is_cfg = 1'b1;
		s.drain  = 1'b1;  // write only with the block idle
		s.cap    = cap;
		s.req    = '0;
		s.gap    = $urandom_range(0, 13);
		req_backlog.push_back(s);
	endtask

	logic [4:0]  phase_caps [8];
	int          mode;
	int          prio_mode;
	int          roll;
	logic [1:0]  code;
	logic [7:0]  prio;

	initial begin
		for (int i = 0; i < DEPTH; i++)
			model_store[i] = '0;

		// directed: empty peek and dequeue, unused code, field extremes,
		// equal-priority order, drop at a small limit, drain to empty
		push_capacity(5'd3);
		push_request(REQ_PEEK, '1, '1, '1, '1, '1, '1, 1'b0);
		push_request(REQ_DEQUEUE, '0, '0, '0, '0, '0, '0, 1'b0);
		push_request(REQ_UNUSED, '1, '1, '1, '1, '1, '1, 1'b0);
		push_request(REQ_ENQUEUE, '0, '0, '0, '0, '0, '0, 1'b0);
		push_request(REQ_ENQUEUE, '1, '1, '1, '1, '1, '1, 1'b0);
		push_request(REQ_ENQUEUE, 16'h1234, 8'hFF, 16'h0001, 8'h01, 8'h80, 32'h8000_0000,
			1'b0);
		push_request(REQ_ENQUEUE, 16'h5555, 8'h80, 16'hAAAA, 8'h55, 8'hAA, 32'h5555_5555,
			1'b0);
		push_request(REQ_PEEK, '0, '0, '0, '0, '0, '0, 1'b0);
		push_request(REQ_DEQUEUE, '0, '0, '0, '0, '0, '0, 1'b0);
		push_request(REQ_ENQUEUE, 16'hAAAA, 8'h7F, 16'h5555, 8'hAA, 8'h55, 32'hAAAA_AAAA,
			1'b0);
		push_request(REQ_DEQUEUE, '0, '0, '0, '0, '0, '0, 1'b0);
		push_request(REQ_DEQUEUE, '0, '0, '0, '0, '0, '0, 1'b0);
		push_request(REQ_DEQUEUE, '0, '0, '0, '0, '0, '0, 1'b0);
		push_request(REQ_DEQUEUE, '0, '0, '0, '0, '0, '0, 1'b0);
		push_request(REQ_UNUSED, '0, '0, '0, '0, '0, '0, 1'b0);

		// capacity settings: full store, single entry, above depth, random,
		// unlimited again, then a limit of four
		phase_caps[0] = 5'd16;
		phase_caps[1] = 5'd1;
		phase_caps[2] = 5'd31;
		phase_caps[3] = 5'd17;
		phase_caps[4] = 5'($urandom_range(2, 15));
		phase_caps[5] = 5'($urandom_range(2, 15));
		phase_caps[6] = 5'd0;
		phase_caps[7] = 5'd4;

		mode = 0;
		prio_mode = 0;
		for (int p = 0; p < 8; p++) begin
			push_capacity(phase_caps[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 24 == 0) begin
					mode      = $urandom_range(0, 2);  // fill, drain, mixed
					prio_mode = $urandom_range(0, 2);  // narrow, full, extremes
				end
				roll = $urandom_range(0, 99);
				if (roll < 3)
					code = REQ_UNUSED;
				else if (roll < (mode == 0 ? 78 : (mode == 1 ? 25 : 48)))
					code = REQ_ENQUEUE;
				else if (roll < (mode == 0 ? 90 : (mode == 1 ? 85 : 88)))
					code = REQ_DEQUEUE;
				else
					code = REQ_PEEK;
				case (prio_mode)
					0:       prio = 8'($urandom_range(0, 3));
					1:       prio = 8'($urandom);
					default: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				endcase
				// hold off once per phase until the queue has answered everything
				push_request(code, 16'($urandom), prio, 16'($urandom), 8'($urandom),
					8'($urandom), $urandom, n == PHASE_ITEMS / 2);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || in_valid || cfg_valid || rsp_expected.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && rsp_expected.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
